### hw/rtl/ffia_pkg.sv
// ----------------------------------------------------------------------------
// ffia_pkg
// Shared types and constants of the first-fit interval allocator.
// ----------------------------------------------------------------------------
package ffia_pkg;

    localparam int MACHINES_DEF  = 64;
    localparam int TIME_BITS_DEF = 20;

    localparam int TIME_W = 20;
    localparam int ID_W   = 16;
    localparam int NUM_W  = 7;

    localparam logic CMD_ASSIGN = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } ffia_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } ffia_stat_t;

endpackage

### hw/rtl/ffia_in_if.sv
// ----------------------------------------------------------------------------
// ffia_in_if
// Request channel: valid/ready handshake with one request item.
// ----------------------------------------------------------------------------
interface ffia_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [ffia_pkg::TIME_W-1:0] start_time;
    logic [ffia_pkg::TIME_W-1:0] end_time;
    logic [ffia_pkg::ID_W-1:0]   request_id;

    modport source (output valid, output cmd, output start_time, output end_time,
                    output request_id, input ready);
    modport sink   (input valid, input cmd, input start_time, input end_time,
                    input request_id, output ready);
endinterface

### hw/rtl/ffia_out_if.sv
// ----------------------------------------------------------------------------
// ffia_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface ffia_out_if;
    logic                       valid;
    logic                       ready;
    logic [ffia_pkg::ID_W-1:0]  echo_id;
    logic [ffia_pkg::NUM_W-1:0] resource_number;
    logic [ffia_pkg::NUM_W-1:0] resources_open;
    logic                       full_flag;

    modport source (output valid, output echo_id, output resource_number,
                    output resources_open, output full_flag, input ready);
    modport sink   (input valid, input echo_id, input resource_number,
                    input resources_open, input full_flag, output ready);
endinterface

### hw/rtl/ffia_ctrl.sv
// ----------------------------------------------------------------------------
// ffia_ctrl
// Sequencer: accept, scan of open resources, finish into the output register.
// ----------------------------------------------------------------------------
module ffia_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffia_pkg::ffia_stat_t stat,
    output ffia_pkg::ffia_cmd_t  cmd
);
    import ffia_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_end)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/ffia_datapath.sv
// ----------------------------------------------------------------------------
// ffia_datapath
// Busy-until memory, pipelined first-fit scan, resource count, result register.
// ----------------------------------------------------------------------------
module ffia_datapath
#(
    parameter int MACHINES  = ffia_pkg::MACHINES_DEF,
    parameter int TIME_BITS = ffia_pkg::TIME_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffia_pkg::ffia_cmd_t         cmd,
    output ffia_pkg::ffia_stat_t        stat,
    input  logic                        in_cmd,
    input  logic [ffia_pkg::TIME_W-1:0] in_start,
    input  logic [ffia_pkg::TIME_W-1:0] in_end,
    input  logic [ffia_pkg::ID_W-1:0]   in_id,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ffia_pkg::ID_W-1:0]   out_id,
    output logic [ffia_pkg::NUM_W-1:0]  out_res,
    output logic [ffia_pkg::NUM_W-1:0]  out_open,
    output logic                        out_full
);
    import ffia_pkg::*;

    localparam int CNT_W = $clog2(MACHINES + 1);
    localparam int IDX_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam logic [CNT_W-1:0] MACH_CNT = CNT_W'(MACHINES);

    logic [TIME_BITS-1:0] mem [MACHINES];

    logic                 cmd_reg;
    logic [TIME_BITS-1:0] start_reg;
    logic [TIME_BITS-1:0] stop_reg;
    logic [ID_W-1:0]      id_reg;

    logic [CNT_W-1:0]     open_reg;
    logic [CNT_W-1:0]     open_next;
    logic [CNT_W-1:0]     rd_idx_reg;
    logic                 cmp_vld_reg;
    logic [IDX_W-1:0]     cmp_idx_reg;
    logic [TIME_BITS-1:0] rd_data_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     sel_idx_reg;

    logic                 out_vld_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [NUM_W-1:0]     out_res_reg;
    logic [NUM_W-1:0]     out_open_reg;
    logic                 out_full_reg;

    logic [TIME_BITS+TIME_W-1:0] start_ext;
    logic [TIME_BITS+TIME_W-1:0] stop_ext;
    logic                 is_clear;
    logic                 more;
    logic                 issue;
    logic                 hit;
    logic                 can_open;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [CNT_W-1:0]     res_val;
    logic [CNT_W+NUM_W-1:0] res_ext;
    logic [CNT_W+NUM_W-1:0] open_ext;

    assign start_ext = {{TIME_BITS{1'b0}}, in_start};
    assign stop_ext  = {{TIME_BITS{1'b0}}, in_end};

    assign is_clear = (cmd_reg == CMD_CLEAR);
    assign more     = (rd_idx_reg < open_reg);
    assign issue    = cmd.scan && !is_clear && more;
    assign hit      = cmp_vld_reg && (rd_data_reg < start_reg);

    assign stat.scan_end = is_clear || hit || (!more && !cmp_vld_reg);
    assign stat.out_free = !out_vld_reg || out_ready;

    assign can_open = (open_reg < MACH_CNT);
    assign wr_en    = cmd.finish && !is_clear && (hit_reg || can_open);
    assign wr_idx   = hit_reg ? sel_idx_reg : open_reg[IDX_W-1:0];
    assign res_val  = (!is_clear && (hit_reg || can_open))
                      ? (CNT_W'(wr_idx) + CNT_W'(1)) : '0;

    always_comb
    begin
        open_next = open_reg;
        if (is_clear)
        begin
            open_next = '0;
        end
        else if (!hit_reg && can_open)
        begin
            open_next = open_reg + CNT_W'(1);
        end
    end

    assign res_ext  = {{NUM_W{1'b0}}, res_val};
    assign open_ext = {{NUM_W{1'b0}}, open_next};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_cmd;
            start_reg <= start_ext[TIME_BITS-1:0];
            stop_reg  <= stop_ext[TIME_BITS-1:0];
            id_reg    <= in_id;
        end
        if (wr_en)
        begin
            mem[wr_idx] <= stop_reg;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
            cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.scan && stat.scan_end)
        begin
            sel_idx_reg <= cmp_idx_reg;
        end
        if (cmd.finish)
        begin
            out_id_reg   <= id_reg;
            out_res_reg  <= res_ext[NUM_W-1:0];
            out_open_reg <= open_ext[NUM_W-1:0];
            out_full_reg <= !is_clear && !hit_reg && !can_open;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_idx_reg  <= '0;
                cmp_vld_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_vld_reg <= issue;
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.scan && stat.scan_end)
            begin
                hit_reg <= hit;
            end
            if (cmd.finish)
            begin
                open_reg    <= open_next;
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_id    = out_id_reg;
    assign out_res   = out_res_reg;
    assign out_open  = out_open_reg;
    assign out_full  = out_full_reg;

endmodule

### hw/rtl/first_fit_interval_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_interval_allocator
// Gives each request the lowest-numbered open resource that is free before
// its start, opening a new one when none is and flagging full when all are
// open; a clear item starts a new batch. Requests are handled one at a time.
// The scan reads one busy-until entry per cycle from the resource memory,
// compares it in the cycle after and stops at the first free entry. The
// result sits in an output register, so a new request is taken while the
// previous result waits; the next item then holds in its finish state until
// that result is taken.
// ----------------------------------------------------------------------------
module first_fit_interval_allocator
#(
    parameter int MACHINES  = ffia_pkg::MACHINES_DEF,
    parameter int TIME_BITS = ffia_pkg::TIME_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    ffia_in_if.sink   in_ch,
    ffia_out_if.source out_ch
);
    import ffia_pkg::*;

    ffia_cmd_t  cmd;
    ffia_stat_t stat;

    ffia_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffia_datapath
    #(
        .MACHINES  (MACHINES),
        .TIME_BITS (TIME_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_cmd    (in_ch.cmd),
        .in_start  (in_ch.start_time),
        .in_end    (in_ch.end_time),
        .in_id     (in_ch.request_id),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_id    (out_ch.echo_id),
        .out_res   (out_ch.resource_number),
        .out_open  (out_ch.resources_open),
        .out_full  (out_ch.full_flag)
    );

endmodule

### hw/rtl/ffia_checker.sv
// ----------------------------------------------------------------------------
// ffia_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffia_checker
#(
    parameter int MACHINES = ffia_pkg::MACHINES_DEF
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ffia_pkg::ID_W-1:0]  echo_id,
    input logic [ffia_pkg::NUM_W-1:0] resource_number,
    input logic [ffia_pkg::NUM_W-1:0] resources_open,
    input logic                       full_flag
);
    import ffia_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(echo_id)
            && $stable(resource_number) && $stable(resources_open) && $stable(full_flag))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    a_full_no_res: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_flag |-> resource_number == '0)
        else $error("full result names a resource");

    a_res_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (MACHINES < 128) && out_valid |-> resource_number <= resources_open)
        else $error("resource number beyond open count");

endmodule

bind first_fit_interval_allocator ffia_checker
#(
    .MACHINES (MACHINES)
)
u_ffia_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .echo_id         (out_ch.echo_id),
    .resource_number (out_ch.resource_number),
    .resources_open  (out_ch.resources_open),
    .full_flag       (out_ch.full_flag)
);

### tb/sv/tb_first_fit_interval_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_interval_allocator
// Sends request and clear items to the first-fit allocator and checks every
// result against a cycle-free first-fit predictor kept in step with each
// accepted item. The run covers a directed part, a batch filled to full, and
// random batches under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_first_fit_interval_allocator;
    import ffia_pkg::*;

    localparam int MACHINES     = MACHINES_DEF;
    localparam int CLK_HALF     = 4;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 2 * MACHINES + 16;
    localparam int REPORT_MAX   = 10;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [ID_W-1:0]   request_id;
    } request_t;

    typedef struct packed {
        logic [ID_W-1:0]  echo_id;
        logic [NUM_W-1:0] resource_number;
        logic [NUM_W-1:0] resources_open;
        logic             full_flag;
    } grant_t;

    logic clk;
    logic rst_n;

    ffia_in_if  req_if ();
    ffia_out_if grant_if ();

    first_fit_interval_allocator u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_if),
        .out_ch (grant_if)
    );

    logic [TIME_W-1:0] model_busy_until [MACHINES];
    int unsigned       model_open = 0;
    grant_t            expected_grants [$];
    int unsigned       send_idle_pct = 6;
    int unsigned       recv_idle_pct = 62;
    int unsigned       error_count   = 0;
    int unsigned       stall_cycles  = 0;
    int unsigned       requests_sent = 0;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // first-fit decision on the predictor state
    function automatic grant_t allocate_first_fit(request_t req);
        grant_t g;
        int     slot;
        bit     hit;
        g.echo_id         = req.request_id;
        g.resource_number = '0;
        g.full_flag       = 1'b0;
        hit               = 1'b0;
        slot              = 0;
        if (req.cmd == CMD_CLEAR)
        begin
            model_open = 0;
        end
        else
        begin
            for (int k = 0; k < model_open; k++)
            begin
                if (!hit && model_busy_until[k] < req.start_time)
                begin
                    hit  = 1'b1;
                    slot = k;
                end
            end
            if (!hit && model_open < MACHINES)
            begin
                slot       = model_open;
                model_open = model_open + 1;
                hit        = 1'b1;
            end
            if (hit)
            begin
                model_busy_until[slot] = req.end_time;
                g.resource_number      = NUM_W'(slot + 1);
            end
            else
            begin
                g.full_flag = 1'b1;
            end
        end
        g.resources_open = NUM_W'(model_open);
        return g;
    endfunction

    task automatic send_request(input logic cmd, input logic [TIME_W-1:0] start_time,
                                input logic [TIME_W-1:0] end_time,
                                input logic [ID_W-1:0] request_id);
        request_t req;
        req = '{cmd, start_time, end_time, request_id};
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.cmd        <= cmd;
        req_if.start_time <= start_time;
        req_if.end_time   <= end_time;
        req_if.request_id <= request_id;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_grants.push_back(allocate_first_fit(req));
        requests_sent = requests_sent + 1;
    endtask

    task automatic test_directed_requests();
        send_request(CMD_CLEAR,  20'h0,     20'h0,     16'hFFFF);
        send_request(CMD_ASSIGN, 20'h0,     TIME_MAX,  16'h0000);
        send_request(CMD_ASSIGN, TIME_MAX,  20'h0,     16'h0001);
        send_request(CMD_ASSIGN, 20'h0,     20'h0,     16'h0002);
        send_request(CMD_ASSIGN, 20'h1,     20'h3,     16'h0003);
        send_request(CMD_ASSIGN, 20'h1,     20'h1,     16'h0004);
        // start goes backward
        send_request(CMD_ASSIGN, 20'h0,     20'h7,     16'h0005);
        // end before start
        send_request(CMD_ASSIGN, 20'h10,    20'h2,     16'h0006);
        send_request(CMD_ASSIGN, 20'h80000, 20'h7FFFF, 16'h8000);
        send_request(CMD_ASSIGN, 20'h55555, 20'hAAAAA, 16'h5555);
        send_request(CMD_ASSIGN, 20'hAAAAA, 20'h55555, 16'hAAAA);
        send_request(CMD_CLEAR,  TIME_MAX,  TIME_MAX,  16'h1234);
        send_request(CMD_ASSIGN, 20'h0,     20'h0,     16'h0007);
        send_request(CMD_ASSIGN, TIME_MAX,  TIME_MAX,  16'h0008);
        send_request(CMD_ASSIGN, TIME_MAX,  20'h0,     16'h0009);
    endtask

    // every resource opened and busy, then requests that find none free, then ones at the latest start time
    task automatic test_fill_to_full();
        send_request(CMD_CLEAR, 20'h0, 20'h0, 16'h0100);
        for (int k = 0; k < MACHINES; k++)
            send_request(CMD_ASSIGN, 20'h0, TIME_W'($urandom), ID_W'(k));
        send_request(CMD_ASSIGN, 20'h0, 20'h12345, 16'hFFFE);
        send_request(CMD_ASSIGN, 20'h0, TIME_MAX,  16'h0001);
        send_request(CMD_ASSIGN, TIME_MAX, TIME_MAX, 16'h0200);
        send_request(CMD_ASSIGN, TIME_MAX, 20'h0,    16'h0201);
        send_request(CMD_CLEAR, 20'h0, 20'h0, 16'h0300);
    endtask

    // mostly ordered batches after a clear; some crowded enough to fill up
    task automatic test_random_batches(input int unsigned quota);
        int unsigned       target;
        int unsigned       pick;
        int unsigned       count;
        int unsigned       step_max;
        int unsigned       span_max;
        logic              crowded;
        logic [TIME_W-1:0] t;
        logic [ID_W-1:0]   id;
        target = requests_sent + quota;
        while (requests_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                crowded  = (pick < 8);
                count    = crowded ? $urandom_range(MACHINES + 12, MACHINES)
                                   : $urandom_range(24, 1);
                step_max = crowded ? 2 : $urandom_range(4000, 1);
                span_max = crowded ? 60000 : $urandom_range(20000, 1);
                t        = ($urandom_range(3) == 0) ? TIME_MAX - TIME_W'($urandom_range(50000))
                                                    : TIME_W'($urandom);
                id       = ID_W'($urandom);
                send_request(CMD_CLEAR, TIME_W'($urandom), TIME_W'($urandom), id);
                for (int k = 0; k < count; k++)
                begin
                    t  = t + TIME_W'($urandom_range(step_max));
                    id = id + 1'b1;
                    send_request(CMD_ASSIGN, t, t + TIME_W'($urandom_range(span_max)), id);
                end
            end
            else
            begin
                send_request(($urandom_range(9) == 0) ? CMD_CLEAR : CMD_ASSIGN,
                             TIME_W'($urandom), TIME_W'($urandom), ID_W'($urandom));
            end
        end
    endtask

    initial
    begin
        grant_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            grant_if.ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        grant_t want;
        grant_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && grant_if.valid && grant_if.ready)
            begin
                got = '{grant_if.echo_id, grant_if.resource_number,
                        grant_if.resources_open, grant_if.full_flag};
                if (expected_grants.size() == 0)
                begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_MAX)
                        $display("unexpected result: echo=%0d res=%0d open=%0d full=%0d",
                                 got.echo_id, got.resource_number, got.resources_open,
                                 got.full_flag);
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (got.echo_id !== want.echo_id
                        || got.resource_number !== want.resource_number
                        || got.resources_open !== want.resources_open
                        || got.full_flag !== want.full_flag)
                    begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_MAX)
                            $display({"mismatch: exp echo=%0d res=%0d open=%0d full=%0d",
                                      " got echo=%0d res=%0d open=%0d full=%0d"},
                                     want.echo_id, want.resource_number,
                                     want.resources_open, want.full_flag,
                                     got.echo_id, got.resource_number,
                                     got.resources_open, got.full_flag);
                    end
                end
            end
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (grant_if.valid && grant_if.ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_ASSIGN;
        req_if.start_time = '0;
        req_if.end_time   = '0;
        req_if.request_id = '0;
        for (int k = 0; k < MACHINES; k++)
            model_busy_until[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_fill_to_full();
        test_random_batches(160);

        send_idle_pct = 62;
        recv_idle_pct = 6;
        test_random_batches(160);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_batches(160);

        req_if.valid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_grants.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
